>>> sv/tprp_pkg.sv
// Package for the torus point rotate/project block: field widths, register
// indexes and the quarter-wave sine used to build the angle tables.
// No dependencies.
package tprp_pkg;

    localparam int STEP_W = 8;
    localparam int OUT_W  = 7;
    localparam int COEF_W = 16;
    localparam int RAD_W  = 6;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [RAD_W-1:0]         rad_t;

    typedef enum logic [2:0] {
        REG_COS_X = 3'd0,
        REG_SIN_X = 3'd1,
        REG_COS_Y = 3'd2,
        REG_SIN_Y = 3'd3,
        REG_COS_Z = 3'd4,
        REG_SIN_Z = 3'd5,
        REG_MAJOR = 3'd6,
        REG_MINOR = 3'd7
    } cfg_idx_t;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Q14 sine of r/16384 of a quarter turn, Taylor series in Horner form
    function automatic logic [15:0] quarter_sine(input logic [14:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = 64'(r) * 64'd102944;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + (64'd1 << 15)) >> 16;
        if (s > 64'd16384)
        begin
            s = 64'd16384;
        end
        return 16'(s);
    endfunction

    // signed Q14 sine of a 16-bit turn phase
    function automatic logic signed [15:0] phase_sine(input logic [15:0] phase);
        logic [15:0] m;
        if (phase[14])
        begin
            m = quarter_sine(15'd16384 - {1'b0, phase[13:0]});
        end
        else
        begin
            m = quarter_sine({1'b0, phase[13:0]});
        end
        return phase[15] ? -$signed(m) : $signed(m);
    endfunction

endpackage

>>> sv/tprp_in_if.sv
// Sample channel of the torus point rotate/project block: valid/ready and
// the two step indices. Depends on tprp_pkg.
interface tprp_in_if import tprp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] u_step;
    logic [STEP_W-1:0] v_step;

    modport source (output valid, output u_step, output v_step, input ready);
    modport sink   (input valid, input u_step, input v_step, output ready);
endinterface

>>> sv/tprp_out_if.sv
// Result channel of the torus point rotate/project block: valid/ready and
// grid position, depth level and off-grid flag. Depends on tprp_pkg.
interface tprp_out_if import tprp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] grid_row;
    logic [OUT_W-1:0] grid_col;
    logic [OUT_W-1:0] depth_level;
    logic             off_grid;

    modport source (output valid, output grid_row, output grid_col,
                    output depth_level, output off_grid, input ready);
    modport sink   (input valid, input grid_row, input grid_col,
                    input depth_level, input off_grid, output ready);
endinterface

>>> sv/torus_point_rotate_project_core.sv
// Top level of the torus point rotate/project block: angle tables, rotation
// pipeline, projection and depth search. Depends on tprp_pkg, tprp_in_if,
// tprp_out_if.
//
// Usage
// - sample (sink): one transaction per torus sample, u_step and v_step are
//   step indices; values of STEPS and above wrap modulo STEPS.
// - result (source): one transaction per sample, in order: grid_row,
//   grid_col, depth_level and off_grid (row and column read 0 when off grid).
// - APB port: eight registers at byte addresses 0..28 (x/y/z cos and sin in
//   Q1.14, major and minor radius). Writes take effect at the access cycle;
//   change them only while the pipeline is empty.
// Throughput: one sample per cycle while result.ready is high. The pipe
// has 12 + clog2(LEVELS) register stages: table lookup, torus point (two
// stages), three rotations of a multiply stage and a sum stage each,
// rounding, squaring, distance sum and one stage per bit of the depth
// level binary search.
// Reset: all pipeline stages empty, registers to identity rotation, radii
// 25 and 10.
// Stall: every stage holds while its successor is full and stalled; empty
// stages keep filling, so sample.ready stays high until the whole pipe is
// full. Nothing is dropped or repeated.
module torus_point_rotate_project_core import tprp_pkg::*; #(
    parameter int GRID_SIZE = 100,
    parameter int STEPS     = 200,
    parameter int LEVELS    = 94
) (
    input  logic                clk,
    input  logic                rst_n,
    tprp_in_if.sink             sample,
    tprp_out_if.source          result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // coordinate, product and sum widths (Q28 values, with rotation growth)
    localparam int CW  = 42;
    localparam int PW  = CW + COEF_W;
    localparam int SW  = PW + 1;
    localparam int AW  = 23;
    localparam int DXW = 29;
    localparam int SQW = 2 * DXW;
    localparam int DW  = 60;
    localparam int LW  = $clog2(LEVELS);
    localparam int NST = 12 + LW;
    localparam int HALF_GRID = GRID_SIZE / 2;
    localparam int HALF_STEPS = STEPS / 2;
    localparam logic [95:0] DEPTH_DEN = 96'(4 * LEVELS * LEVELS);
    localparam logic [95:0] DEPTH_NUM = 96'(5 * GRID_SIZE * GRID_SIZE);
    localparam logic signed [SW-1:0] HALF14 = SW'(8192);

    // ------------------------------------------------------------------
    // angle tables, indexed by the raw 8-bit step
    // ------------------------------------------------------------------
    function automatic logic [15:0] step_phase(input int k);
        logic [31:0] kk;
        logic [31:0] ph;
        kk = 32'(k % STEPS);
        ph = ((kk << 16) + 32'(HALF_STEPS)) / STEPS;
        return 16'(ph);
    endfunction

    function automatic logic [255:0][15:0] build_trig(input logic quarter);
        logic [255:0][15:0] tab;
        logic [15:0]        ph;
        for (int k = 0; k < 256; k++)
        begin
            ph = step_phase(k) + (quarter ? 16'd16384 : 16'd0);
            tab[k] = phase_sine(ph);
        end
        return tab;
    endfunction

    // smallest distance sum per level: ceil(L^2*5*G^2*2^28 / (4*LEVELS^2))
    function automatic logic [LEVELS-1:0][DW-1:0] build_thr();
        logic [LEVELS-1:0][DW-1:0] thr;
        logic [95:0]               num;
        for (int l = 0; l < LEVELS; l++)
        begin
            num = (96'(l * l) * DEPTH_NUM) << 28;
            thr[l] = DW'((num + DEPTH_DEN - 96'd1) / DEPTH_DEN);
        end
        return thr;
    endfunction

    localparam logic [255:0][15:0]        SIN_TAB = build_trig(1'b0);
    localparam logic [255:0][15:0]        COS_TAB = build_trig(1'b1);
    localparam logic [LEVELS-1:0][DW-1:0] THR_TAB = build_thr();

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    coef_t cos_x_reg, sin_x_reg, cos_y_reg, sin_y_reg, cos_z_reg, sin_z_reg;
    rad_t  major_reg, minor_reg;
    cfg_idx_t cfg_idx;

    assign cfg_idx = cfg_idx_t'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_x_reg <= 16'sd16384;
            sin_x_reg <= '0;
            cos_y_reg <= 16'sd16384;
            sin_y_reg <= '0;
            cos_z_reg <= 16'sd16384;
            sin_z_reg <= '0;
            major_reg <= 6'd25;
            minor_reg <= 6'd10;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_idx)
                REG_COS_X: cos_x_reg <= pwdata[15:0];
                REG_SIN_X: sin_x_reg <= pwdata[15:0];
                REG_COS_Y: cos_y_reg <= pwdata[15:0];
                REG_SIN_Y: sin_y_reg <= pwdata[15:0];
                REG_COS_Z: cos_z_reg <= pwdata[15:0];
                REG_SIN_Z: sin_z_reg <= pwdata[15:0];
                REG_MAJOR: major_reg <= pwdata[RAD_W-1:0];
                REG_MINOR: minor_reg <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_COS_X: prdata = {16'd0, cos_x_reg};
            REG_SIN_X: prdata = {16'd0, sin_x_reg};
            REG_COS_Y: prdata = {16'd0, cos_y_reg};
            REG_SIN_Y: prdata = {16'd0, sin_y_reg};
            REG_COS_Z: prdata = {16'd0, cos_z_reg};
            REG_SIN_Z: prdata = {16'd0, sin_z_reg};
            REG_MAJOR: prdata = {26'd0, major_reg};
            REG_MINOR: prdata = {26'd0, minor_reg};
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control: a stage loads when empty or when it moves on
    // ------------------------------------------------------------------
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_prev;
    logic [NST:0]   adv;

    assign valid_prev = {valid_reg[NST-2:0], sample.valid};

    always_comb
    begin
        adv[NST] = result.ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign sample.ready = adv[0];
    assign result.valid = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_prev[i];
                end
            end
        end
    end

    // rounding of a Q42 sum back to Q28: floor((s + 2^13) / 2^14)
    function automatic logic signed [CW-1:0] rnd14(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] t;
        t = s + HALF14;
        return CW'(t >>> 14);
    endfunction

    // stage 0: table lookup
    coef_t su_reg, cu_reg, sv_reg, cv_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            su_reg <= SIN_TAB[sample.u_step];
            cu_reg <= COS_TAB[sample.u_step];
            sv_reg <= SIN_TAB[sample.v_step];
            cv_reg <= COS_TAB[sample.v_step];
        end
    end

    // stage 1: tube radius term and z before scaling
    logic signed [AW-1:0] r2cv, r2sv, a_next;
    logic signed [AW-1:0] a_reg, zs_reg;
    coef_t                cu1_reg, su1_reg;

    assign r2cv   = $signed({1'b0, minor_reg}) * cv_reg;
    assign r2sv   = $signed({1'b0, minor_reg}) * sv_reg;
    assign a_next = $signed({3'd0, major_reg, 14'd0}) + r2cv;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            a_reg   <= a_next;
            zs_reg  <= r2sv;
            cu1_reg <= cu_reg;
            su1_reg <= su_reg;
        end
    end

    // stage 2: torus point in Q28
    logic signed [CW-1:0] x0_next, y0_next, z0_next;
    logic signed [CW-1:0] x0_reg, y0_reg, z0_reg;

    assign x0_next = a_reg * cu1_reg;
    assign y0_next = a_reg * su1_reg;
    assign z0_next = $signed({{(CW-AW-14){zs_reg[AW-1]}}, zs_reg, 14'd0});

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            z0_reg <= z0_next;
        end
    end

    // stages 3/4: rotation about x
    logic signed [PW-1:0] p1_reg [4];
    logic signed [CW-1:0] x1c_reg;
    logic signed [CW-1:0] y1_reg, z1_reg, x1_reg;
    logic signed [SW-1:0] s1a, s1b;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            p1_reg[0] <= y0_reg * cos_x_reg;
            p1_reg[1] <= z0_reg * sin_x_reg;
            p1_reg[2] <= y0_reg * sin_x_reg;
            p1_reg[3] <= z0_reg * cos_x_reg;
            x1c_reg   <= x0_reg;
        end
    end

    assign s1a = SW'(p1_reg[0]) - SW'(p1_reg[1]);
    assign s1b = SW'(p1_reg[2]) + SW'(p1_reg[3]);

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            y1_reg <= rnd14(s1a);
            z1_reg <= rnd14(s1b);
            x1_reg <= x1c_reg;
        end
    end

    // stages 5/6: rotation about y
    logic signed [PW-1:0] p2_reg [4];
    logic signed [CW-1:0] y2c_reg;
    logic signed [CW-1:0] x2_reg, z2_reg, y2_reg;
    logic signed [SW-1:0] s2a, s2b;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            p2_reg[0] <= x1_reg * cos_y_reg;
            p2_reg[1] <= z1_reg * sin_y_reg;
            p2_reg[2] <= z1_reg * cos_y_reg;
            p2_reg[3] <= x1_reg * sin_y_reg;
            y2c_reg   <= y1_reg;
        end
    end

    assign s2a = SW'(p2_reg[0]) + SW'(p2_reg[1]);
    assign s2b = SW'(p2_reg[2]) - SW'(p2_reg[3]);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            x2_reg <= rnd14(s2a);
            z2_reg <= rnd14(s2b);
            y2_reg <= y2c_reg;
        end
    end

    // stages 7/8: rotation about z
    logic signed [PW-1:0] p3_reg [4];
    logic signed [CW-1:0] z3c_reg;
    logic signed [CW-1:0] x3_reg, y3_reg, z3_reg;
    logic signed [SW-1:0] s3a, s3b;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            p3_reg[0] <= x2_reg * cos_z_reg;
            p3_reg[1] <= y2_reg * sin_z_reg;
            p3_reg[2] <= x2_reg * sin_z_reg;
            p3_reg[3] <= y2_reg * cos_z_reg;
            z3c_reg   <= z2_reg;
        end
    end

    assign s3a = SW'(p3_reg[0]) - SW'(p3_reg[1]);
    assign s3b = SW'(p3_reg[2]) + SW'(p3_reg[3]);

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            x3_reg <= rnd14(s3a);
            y3_reg <= rnd14(s3b);
            z3_reg <= z3c_reg;
        end
    end

    // stage 9: grid position (half away from zero) and Q14 coordinates
    function automatic logic signed [16:0] grid_pos(input logic signed [CW-1:0] c);
        logic [CW-1:0] m;
        logic [CW-1:0] r;
        logic [15:0]   rmag;
        logic signed [16:0] rs;
        m    = c[CW-1] ? CW'(-c) : CW'(c);
        r    = (m + (CW'(1) << 27)) >> 28;
        rmag = 16'(r);
        rs   = c[CW-1] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
        return rs + 17'(HALF_GRID);
    endfunction

    function automatic logic signed [DXW-1:0] q14(input logic signed [CW-1:0] c);
        logic signed [CW:0] t;
        t = (CW+1)'(c) + (CW+1)'(8192);
        return DXW'(t >>> 14);
    endfunction

    logic signed [16:0]    row_s, col_s;
    logic                  off_next;
    logic [OUT_W-1:0]      row9_reg, col9_reg;
    logic                  off9_reg;
    logic signed [DXW-1:0] dx_reg, dy_reg, dz_reg;

    assign row_s    = grid_pos(x3_reg);
    assign col_s    = grid_pos(y3_reg);
    assign off_next = (row_s < 17'sd0) || (row_s >= 17'(GRID_SIZE)) ||
                      (col_s < 17'sd0) || (col_s >= 17'(GRID_SIZE));

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            row9_reg <= off_next ? '0 : row_s[OUT_W-1:0];
            col9_reg <= off_next ? '0 : col_s[OUT_W-1:0];
            off9_reg <= off_next;
            dx_reg   <= q14(x3_reg);
            dy_reg   <= q14(y3_reg);
            dz_reg   <= q14(z3_reg);
        end
    end

    // stage 10: squares
    logic signed [SQW-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [OUT_W-1:0]      row10_reg, col10_reg;
    logic                  off10_reg;

    always_ff @(posedge clk)
    begin
        if (adv[10])
        begin
            sqx_reg   <= dx_reg * dx_reg;
            sqy_reg   <= dy_reg * dy_reg;
            sqz_reg   <= dz_reg * dz_reg;
            row10_reg <= row9_reg;
            col10_reg <= col9_reg;
            off10_reg <= off9_reg;
        end
    end

    // stage 11: squared distance in Q28
    logic [DW-1:0]    d_reg;
    logic [OUT_W-1:0] row11_reg, col11_reg;
    logic             off11_reg;

    always_ff @(posedge clk)
    begin
        if (adv[11])
        begin
            d_reg     <= DW'(unsigned'(sqx_reg)) + DW'(unsigned'(sqy_reg)) +
                         DW'(unsigned'(sqz_reg));
            row11_reg <= row10_reg;
            col11_reg <= col10_reg;
            off11_reg <= off10_reg;
        end
    end

    // stages 12..: depth level, one bit per stage, MSB first
    logic [LW-1:0]    lvl_reg [LW];
    logic [DW-1:0]    sd_reg  [LW];
    logic [OUT_W-1:0] srow_reg [LW];
    logic [OUT_W-1:0] scol_reg [LW];
    logic             soff_reg [LW];

    for (genvar s = 0; s < LW; s++)
    begin : g_srch
        logic [LW-1:0]    lvl_in, cand, idx, lvl_next;
        logic [DW-1:0]    d_in;
        logic [OUT_W-1:0] row_in, col_in;
        logic             off_in;

        if (s == 0)
        begin : g_first
            assign lvl_in = '0;
            assign d_in   = d_reg;
            assign row_in = row11_reg;
            assign col_in = col11_reg;
            assign off_in = off11_reg;
        end
        else
        begin : g_next
            assign lvl_in = lvl_reg[s-1];
            assign d_in   = sd_reg[s-1];
            assign row_in = srow_reg[s-1];
            assign col_in = scol_reg[s-1];
            assign off_in = soff_reg[s-1];
        end

        always_comb
        begin
            cand = lvl_in | (LW'(1) << (LW - 1 - s));
            idx  = (32'(cand) < LEVELS) ? cand : '0;
            if ((32'(cand) < LEVELS) && (d_in >= THR_TAB[idx]))
            begin
                lvl_next = cand;
            end
            else
            begin
                lvl_next = lvl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[12+s])
            begin
                lvl_reg[s]  <= lvl_next;
                sd_reg[s]   <= d_in;
                srow_reg[s] <= row_in;
                scol_reg[s] <= col_in;
                soff_reg[s] <= off_in;
            end
        end
    end

    assign result.grid_row    = srow_reg[LW-1];
    assign result.grid_col    = scol_reg[LW-1];
    assign result.off_grid    = soff_reg[LW-1];
    assign result.depth_level = OUT_W'({{OUT_W{1'b0}}, lvl_reg[LW-1]});

endmodule
